FILE: rtl/core/iirb_pkg.sv
// Shared types, codes and constants for the indexed insert/remove buffer.
package iirb_pkg;

    // Default number of byte cells in the buffer.
    localparam int CAPACITY_DEF = 256;

    // Taps collected by one first-level read group.
    localparam int GROUP = 64;

    // Field widths fixed by the command and result formats.
    localparam int KIND_W = 2;
    localparam int POS_W  = 9;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int FILL_W = 9;

    // Operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_MERGE = 1'b1
    } t_state;

    // One command beat.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] byte_in;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill;
    } t_result;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

endpackage

FILE: rtl/core/iirb_cell.sv
// One byte cell of the shifting chain.
module iirb_cell #(
    parameter int INDEX = 0
) (
    input  logic                          i_clk,
    input  iirb_pkg::t_cell_ctl           i_ctl,
    input  logic [iirb_pkg::BYTE_W-1:0]   i_left,
    input  logic [iirb_pkg::BYTE_W-1:0]   i_right,
    output logic [iirb_pkg::BYTE_W-1:0]   o_data,
    output logic [iirb_pkg::BYTE_W-1:0]   o_tap
);

    // A cell past the reach of the position field never matches it.
    localparam bit BEYOND = (INDEX >> iirb_pkg::POS_W) != 0;
    localparam logic [iirb_pkg::POS_W-1:0] IDX = iirb_pkg::POS_W'(INDEX);

    logic [iirb_pkg::BYTE_W-1:0] r_data;
    logic [iirb_pkg::BYTE_W-1:0] n_data;
    logic                        w_at;
    logic                        w_above;

    // Where this cell sits relative to the addressed position.
    assign w_at    = !BEYOND && (IDX == i_ctl.pos);
    assign w_above = BEYOND || (IDX > i_ctl.pos);

    // Insert moves later bytes up; remove pulls the addressed and later bytes down.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_data = i_left;
            end else if (w_at) begin
                n_data = i_ctl.data;
            end
        end else if (i_ctl.rem) begin
            if (w_at || w_above) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Only the addressed cell drives its byte onto the read tree.
    assign o_data = r_data;
    assign o_tap  = w_at ? r_data : '0;

endmodule

FILE: rtl/core/iirb_group.sv
// First-level registered OR stage of the read tree over one group of cells.
module iirb_group #(
    parameter int N = iirb_pkg::GROUP
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [N-1:0][iirb_pkg::BYTE_W-1:0]  i_taps,
    output logic [iirb_pkg::BYTE_W-1:0]         o_byte
);

    logic [iirb_pkg::BYTE_W-1:0] r_byte;
    logic [iirb_pkg::BYTE_W-1:0] n_byte;

    // At most one tap in the whole buffer is nonzero, so OR selects it.
    always_comb begin
        n_byte = '0;
        for (int k = 0; k < N; k++) begin
            n_byte = n_byte | i_taps[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

FILE: rtl/core/indexed_insert_remove_buffer.sv
// Top level of the indexed insert/remove byte buffer built as a chain of cells.
//
// Usage: a command beat (kind, position, byte_in) on i_cmd is taken at a rising
// edge where start is high and busy is low. Read returns the byte at position,
// insert puts byte_in at position and moves later bytes up, remove returns the
// byte at position and moves later bytes down. Every command gives exactly one
// result beat on o_result, marked by o_strobe for one cycle, with the status
// and the sequence length after the command.
// Flow: a command taken at an edge is held in the merge state, during which busy
// is high, so a new command is taken only once the merge state has passed. All
// cells shift together at the accepting edge; the read tree has one registered OR
// stage per group of 64 cells and then a final merge, registered into the result
// at the end of the merge state.
// Reset (synchronous, active low) empties the sequence and idles the control;
// cell contents are undefined until written, and only written cells are read.
// The receiver cannot stall: each result is valid for its single strobe cycle.
module indexed_insert_remove_buffer #(
    parameter int CAPACITY = iirb_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  iirb_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output iirb_pkg::t_result o_result
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > iirb_pkg::POS_W) ? LEN_W : iirb_pkg::POS_W;
    localparam int NGROUP = (CAPACITY + iirb_pkg::GROUP - 1) / iirb_pkg::GROUP;
    localparam int PAD    = NGROUP * iirb_pkg::GROUP;

    iirb_pkg::t_state            r_state;
    iirb_pkg::t_state            n_state;
    logic [LEN_W-1:0]            r_len;
    logic [LEN_W-1:0]            n_len;
    logic                        r_want;
    logic [iirb_pkg::STAT_W-1:0] r_status;
    logic [iirb_pkg::FILL_W-1:0] r_fill;
    logic                        r_strobe;
    iirb_pkg::t_result           r_result;
    iirb_pkg::t_result           n_result;

    logic                        w_accept;
    logic [CMP_W-1:0]            w_pos;
    logic [CMP_W-1:0]            w_len;
    logic                        w_below;
    logic                        w_past;
    logic                        w_full;
    logic                        w_ins_ok;
    logic                        w_rem_ok;
    logic                        w_want;
    logic [iirb_pkg::STAT_W-1:0] w_status;
    logic [iirb_pkg::BYTE_W-1:0] w_merged;
    iirb_pkg::t_cell_ctl         w_ctl;

    logic [CAPACITY-1:0][iirb_pkg::BYTE_W-1:0] w_data;
    logic [PAD-1:0][iirb_pkg::BYTE_W-1:0]      w_taps;
    logic [NGROUP-1:0][iirb_pkg::BYTE_W-1:0]   w_groups;

    assign w_accept = start && !busy;

    // Range and capacity checks against the current length.
    assign w_pos   = CMP_W'(i_cmd.position);
    assign w_len   = CMP_W'(r_len);
    assign w_below = w_pos < w_len;
    assign w_past  = w_pos > w_len;
    assign w_full  = r_len == LEN_W'(CAPACITY);

    // Command decode: status, byte return and length update.
    always_comb begin
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_want   = 1'b0;
        w_status = iirb_pkg::ST_RANGE;
        case (i_cmd.kind)
            iirb_pkg::KIND_READ: begin
                w_want   = w_below;
                w_status = w_below ? iirb_pkg::ST_DONE : iirb_pkg::ST_RANGE;
            end
            iirb_pkg::KIND_INSERT: begin
                if (w_past) begin
                    w_status = iirb_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = iirb_pkg::ST_FULL;
                end else begin
                    w_status = iirb_pkg::ST_DONE;
                    w_ins_ok = 1'b1;
                end
            end
            iirb_pkg::KIND_REMOVE: begin
                w_rem_ok = w_below;
                w_want   = w_below;
                w_status = w_below ? iirb_pkg::ST_DONE : iirb_pkg::ST_RANGE;
            end
            default: begin
                w_status = iirb_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_len = r_len;
        if (w_accept && w_ins_ok) begin
            n_len = r_len + LEN_W'(1);
        end else if (w_accept && w_rem_ok) begin
            n_len = r_len - LEN_W'(1);
        end
    end

    // Broadcast control to the cell chain; cells move only on an accepted beat.
    assign w_ctl.ins  = w_accept && w_ins_ok;
    assign w_ctl.rem  = w_accept && w_rem_ok;
    assign w_ctl.pos  = i_cmd.position;
    assign w_ctl.data = i_cmd.byte_in;

    // The chain of cells, each wired to its neighbors; an end cell uses its own byte in place of the missing one.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [iirb_pkg::BYTE_W-1:0] w_left;
        logic [iirb_pkg::BYTE_W-1:0] w_right;

        if (i == 0) begin : g_first
            assign w_left = w_data[i];
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_data[i];
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end

        iirb_cell #(
            .INDEX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[i]),
            .o_tap   (w_taps[i])
        );
    end

    // Pad the tap row to whole groups.
    for (genvar p = CAPACITY; p < PAD; p++) begin : g_pad
        assign w_taps[p] = '0;
    end

    // First level of the read tree, captured at the accepting edge.
    for (genvar g = 0; g < NGROUP; g++) begin : g_group
        iirb_group #(
            .N (iirb_pkg::GROUP)
        ) u_group (
            .i_clk  (i_clk),
            .i_en   (w_accept),
            .i_taps (w_taps[g*iirb_pkg::GROUP +: iirb_pkg::GROUP]),
            .o_byte (w_groups[g])
        );
    end

    // Final merge of the group results.
    always_comb begin
        w_merged = '0;
        for (int k = 0; k < NGROUP; k++) begin
            w_merged = w_merged | w_groups[k];
        end
    end

    // Controller: accept in idle, merge in the following cycle and register the result for the strobe.
    always_comb begin
        n_state           = r_state;
        n_result.byte_out = r_want ? w_merged : '0;
        n_result.status   = r_status;
        n_result.fill     = r_fill;
        case (r_state)
            iirb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = iirb_pkg::S_MERGE;
                end
            end
            iirb_pkg::S_MERGE: begin
                n_state = iirb_pkg::S_IDLE;
            end
            default: begin
                n_state = iirb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iirb_pkg::S_IDLE;
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_strobe <= r_state == iirb_pkg::S_MERGE;
        end
    end

    // Beat payload held between accept and merge, and the result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_want   <= w_want;
            r_status <= w_status;
            r_fill   <= iirb_pkg::FILL_W'(n_len);
        end
        if (r_state == iirb_pkg::S_MERGE) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_state == iirb_pkg::S_MERGE;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The merge cycle always follows an accepted beat.
    a_merge_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == iirb_pkg::S_MERGE |-> $past(w_accept))
        else $error("merge cycle without an accepted beat");

    // A result beat always follows a merge cycle.
    a_strobe_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == iirb_pkg::S_MERGE))
        else $error("result strobe without a merge cycle");

    // The length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("length beyond capacity");

    // A failed command returns a zero byte.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != iirb_pkg::ST_DONE |-> o_result.byte_out == '0)
        else $error("nonzero byte on a failed command");

    // Length changes only after an accepted beat; the decode moves it by at most one.
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(w_accept) |-> r_len == $past(r_len))
        else $error("length changed without an accepted beat");

endmodule
